[sv/aesd_pkg.sv]
// ----------------------------------------------------------------------------
// aesd_pkg: shared types, constants and GF(2^8) helpers for the AES-128
// block decryptor.
// ----------------------------------------------------------------------------
package aesd_pkg;

	localparam int unsigned ROUNDS   = 10;
	localparam int unsigned RK_DEPTH = ROUNDS + 1;
	localparam int unsigned RK_AW    = $clog2(RK_DEPTH);
	localparam int unsigned KEY_W    = 64;

	// configuration register indexes
	localparam logic CFG_KEY_HI = 1'b0;
	localparam logic CFG_KEY_LO = 1'b1;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] POLY       = 8'h1b;

	typedef enum logic [1:0] {
		ST_EXPAND,
		ST_IDLE,
		ST_ADD,
		ST_ROUND
	} state_t;

	// forward S-box, entry 0 in the top byte
	localparam logic [2047:0] SBOX_TBL = {
		128'h637C777BF26B6FC53001672BFED7AB76, 128'hCA82C97DFA5947F0ADD4A2AF9CA472C0,
		128'hB7FD9326363FF7CC34A5E5F171D83115, 128'h04C723C31896059A071280E2EB27B275,
		128'h09832C1A1B6E5AA0523BD6B329E32F84, 128'h53D100ED20FCB15B6ACBBE394A4C58CF,
		128'hD0EFAAFB434D338545F9027F503C9FA8, 128'h51A3408F929D38F5BCB6DA2110FFF3D2,
		128'hCD0C13EC5F974417C4A77E3D645D1973, 128'h60814FDC222A908846EEB814DE5E0BDB,
		128'hE0323A0A4906245CC2D3AC629195E479, 128'hE7C8376D8DD54EA96C56F4EA657AAE08,
		128'hBA78252E1CA6B4C6E8DD741F4BBD8B8A, 128'h703EB5664803F60E613557B986C11D9E,
		128'hE1F8981169D98E949B1E87E9CE5528DF, 128'h8CA1890DBFE6426841992D0FB054BB16
	};

	// inverse S-box, entry 0 in the top byte
	localparam logic [2047:0] INV_SBOX_TBL = {
		128'h52096AD53036A538BF40A39E81F3D7FB, 128'h7CE339829B2FFF87348E4344C4DEE9CB,
		128'h547B9432A6C2233DEE4C950B42FAC34E, 128'h082EA16628D924B2765BA2496D8BD125,
		128'h72F8F66486689816D4A45CCC5D65B692, 128'h6C704850FDEDB9DA5E154657A78D9D84,
		128'h90D8AB008CBCD30AF7E45805B8B34506, 128'hD02C1E8FCA3F0F02C1AFBD0301138A6B,
		128'h3A9111414F67DCEA97F2CFCEF0B4E673, 128'h96AC7422E7AD3585E2F937E81C75DF6E,
		128'h47F11A711D29C5896FB7620EAA18BE1B, 128'hFC563E4BC6D279209ADBC0FE78CD5AF4,
		128'h1FDDA8338807C731B11210592780EC5F, 128'h60517FA919B54A0D2DE57A9F93C99CEF,
		128'hA0E03B4DAE2AF5B0C8EBBB3C83539961, 128'h172B047EBA77D626E169146355210C7D
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX_TBL[(11'd255 - {3'd0, x}) * 11'd8 +: 8];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		return INV_SBOX_TBL[(11'd255 - {3'd0, x}) * 11'd8 +: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// inverse mix of one column, row 0 in the top byte
	function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
		logic [7:0] a [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		logic [7:0] x2, x4, x8;
		for (int r = 0; r < 4; r++) begin
			a[r]  = col[31 - 8 * r -: 8];
			x2    = xtime(a[r]);
			x4    = xtime(x2);
			x8    = xtime(x4);
			m9[r] = x8 ^ a[r];
			mb[r] = x8 ^ x2 ^ a[r];
			md[r] = x8 ^ x4 ^ a[r];
			me[r] = x8 ^ x4 ^ x2;
		end
		return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
		        m9[0] ^ me[1] ^ mb[2] ^ md[3],
		        md[0] ^ m9[1] ^ me[2] ^ mb[3],
		        mb[0] ^ md[1] ^ m9[2] ^ me[3]};
	endfunction

endpackage

[sv/aesd_ram.sv]
// ----------------------------------------------------------------------------
// aesd_ram: generic single-port-write, single-port-read RAM
// Read data is registered.
// ----------------------------------------------------------------------------
module aesd_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[sv/aes128_block_decrypt.sv]
// ----------------------------------------------------------------------------
// aes128_block_decrypt: AES-128 block decryption, one round per cycle, the last round waiting on a full output register
//
// Ciphertext items enter on s_tvalid/s_tready/s_tdata, plaintext items leave
// on m_tvalid/m_tready/m_tdata. The key is written through cfg_we/cfg_idx/
// cfg_data (index 0: upper key half, index 1: lower key half).
// Any key write expands the key into 11 round keys, one per cycle, held in
// an 11 x 128-bit RAM; s_tready stays low until the expansion completes.
// After reset the all-zero key is expanded the same way.
// An accepted item passes through the initial key addition (ST_ADD) and
// the ten rounds (ST_ROUND) to the result register, each round fetching its
// key from the registered RAM read port one state ahead. The single shared
// round unit works on one item at a time: the next item is accepted only in
// the idle state after the last round. The result sits in an output
// register; a new item is accepted while it waits. If the receiver stalls
// and the register is still full when the last round finishes, the round
// unit holds until the register drains.
// ----------------------------------------------------------------------------
module aes128_block_decrypt (
	input  logic                              clk,
	input  logic                              arst_n,
	// ct_hi [63:0], ct_lo [127:64]
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [127:0]                      s_tdata,
	// pt_hi [63:0], pt_lo [127:64]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [127:0]                      m_tdata,
	input  logic                              cfg_we,
	input  logic                              cfg_idx,
	input  logic [aesd_pkg::KEY_W-1:0]        cfg_data
);

	aesd_pkg::state_t state_q, state_d;

	logic [aesd_pkg::KEY_W-1:0] key_hi_q, key_lo_q;
	logic [127:0]               kexp_q;
	logic [7:0]                 rcon_q;
	logic [aesd_pkg::RK_AW-1:0] cnt_q;
	logic [127:0]               st_q;
	logic [127:0]               out_q;
	logic                       out_valid_q;

	logic                       ram_we;
	logic [aesd_pkg::RK_AW-1:0] ram_raddr;
	logic [127:0]               rk;
	logic [127:0]               kexp_next;
	logic [127:0]               round_out;
	logic [127:0]               ct_blk;
	logic                       key_write;
	logic                       last_round;
	logic                       out_load;

	assign key_write  = cfg_we;
	assign last_round = (cnt_q == '0);
	assign out_load   = (state_q == aesd_pkg::ST_ROUND) && last_round
	                    && (!out_valid_q || m_tready);
	assign ct_blk     = {s_tdata[63:0], s_tdata[127:64]};

	aesd_ram #(
		.WIDTH(128),
		.DEPTH(aesd_pkg::RK_DEPTH)
	) u_rk_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q),
		.wdata(kexp_q),
		.raddr(ram_raddr),
		.rdata(rk)
	);

	// next round key from the current one
	always_comb begin
		logic [31:0] t, n0, n1, n2, n3;
		t  = aesd_pkg::sub_word({kexp_q[23:0], kexp_q[31:24]}) ^ {rcon_q, 24'd0};
		n0 = kexp_q[127:96] ^ t;
		n1 = kexp_q[95:64] ^ n0;
		n2 = kexp_q[63:32] ^ n1;
		n3 = kexp_q[31:0] ^ n2;
		kexp_next = {n0, n1, n2, n3};
	end

	// one inverse round: shift, substitute, add key, optionally mix
	always_comb begin
		logic [127:0] t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (c * 4 + r) -: 8] = aesd_pkg::inv_sbox(
					st_q[127 - 8 * ((((c - r) + 4) % 4) * 4 + r) -: 8]);
			end
		end
		t = t ^ rk;
		round_out = t;
		if (!last_round) begin
			for (int c = 0; c < 4; c++) begin
				round_out[127 - 32 * c -: 32] = aesd_pkg::inv_mix_col(t[127 - 32 * c -: 32]);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			aesd_pkg::ST_EXPAND: begin
				if (cnt_q == aesd_pkg::RK_AW'(aesd_pkg::ROUNDS)) state_d = aesd_pkg::ST_IDLE;
			end
			aesd_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = aesd_pkg::ST_ADD;
			end
			aesd_pkg::ST_ADD: begin
				state_d = aesd_pkg::ST_ROUND;
			end
			aesd_pkg::ST_ROUND: begin
				if (out_load) state_d = aesd_pkg::ST_IDLE;
			end
			default: state_d = aesd_pkg::ST_IDLE;
		endcase
		if (key_write) state_d = aesd_pkg::ST_EXPAND;
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = aesd_pkg::RK_AW'(aesd_pkg::ROUNDS);
		case (state_q)
			aesd_pkg::ST_EXPAND: begin
				ram_we = 1'b1;
			end
			aesd_pkg::ST_IDLE: begin
				s_tready = !key_write;
			end
			aesd_pkg::ST_ADD: begin
				ram_raddr = aesd_pkg::RK_AW'(aesd_pkg::ROUNDS - 1);
			end
			aesd_pkg::ST_ROUND: begin
				ram_raddr = last_round ? cnt_q : cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer, key registers and expansion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aesd_pkg::ST_EXPAND;
			cnt_q    <= '0;
			key_hi_q <= '0;
			key_lo_q <= '0;
			kexp_q   <= '0;
			rcon_q   <= aesd_pkg::RCON_FIRST;
		end else begin
			state_q <= state_d;
			if (key_write) begin
				cnt_q  <= '0;
				rcon_q <= aesd_pkg::RCON_FIRST;
				if (cfg_idx == aesd_pkg::CFG_KEY_HI) begin
					key_hi_q <= cfg_data;
					kexp_q   <= {cfg_data, key_lo_q};
				end else begin
					key_lo_q <= cfg_data;
					kexp_q   <= {key_hi_q, cfg_data};
				end
			end else begin
				case (state_q)
					aesd_pkg::ST_EXPAND: begin
						kexp_q <= kexp_next;
						rcon_q <= aesd_pkg::xtime(rcon_q);
						cnt_q  <= cnt_q + 1'b1;
					end
					aesd_pkg::ST_ADD: begin
						cnt_q <= aesd_pkg::RK_AW'(aesd_pkg::ROUNDS - 1);
					end
					aesd_pkg::ST_ROUND: begin
						if (!last_round) cnt_q <= cnt_q - 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	// block state: load, initial key add, rounds
	always_ff @(posedge clk) begin
		case (state_q)
			aesd_pkg::ST_IDLE: begin
				if (s_tvalid) st_q <= ct_blk;
			end
			aesd_pkg::ST_ADD: begin
				st_q <= st_q ^ rk;
			end
			aesd_pkg::ST_ROUND: begin
				if (!last_round) st_q <= round_out;
			end
			default: ;
		endcase
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= round_out;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q[63:0], out_q[127:64]};

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for aes128_block_decrypt
//
// Decrypts ciphertext items under several keys and compares each plaintext
// item with a behavioral AES-128 inverse cipher kept in the bench. Starts
// with a directed table (standard test vectors, all-zero and all-one blocks),
// then runs random items under changing keys and idling patterns, including
// one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIMIT_CYCLES = 2000000;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
	} block_t;

	typedef struct {
		logic [63:0] ct_hi;
		logic [63:0] ct_lo;
		bit          known;
		logic [63:0] pt_hi;
		logic [63:0] pt_lo;
	} vector_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic         cfg_we;
	logic         cfg_idx;
	logic [63:0]  cfg_data;

	// bench copy of the key and its schedule
	logic [63:0]  key_hi_q;
	logic [63:0]  key_lo_q;
	logic [31:0]  sched [44];

	block_t       plain_q [$];
	int           errors;
	int           n_sent;
	int           n_recv;
	int           n_keys;
	int           send_idle_pct;
	int           recv_stall_pct;
	bit           hold_off;
	longint       cycles;

	aes128_block_decrypt i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// GF(2^8) arithmetic and tables, written independently of the package
	function automatic logic [7:0] gf_dbl(input logic [7:0] v);
		return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = gf_dbl(a);
		end
		return p;
	endfunction

	function automatic logic [7:0] gf_inv(input logic [7:0] a);
		logic [7:0] r;
		r = 8'h00;
		for (int c = 1; c < 256; c++)
			if (gf_mul(a, 8'(c)) == 8'h01)
				r = 8'(c);
		return r;
	endfunction

	logic [7:0] fwd_box [256];
	logic [7:0] rev_box [256];

	function automatic logic [7:0] affine(input logic [7:0] b);
		logic [7:0] s;
		for (int i = 0; i < 8; i++)
			s[i] = b[i] ^ b[(i + 4) % 8] ^ b[(i + 5) % 8] ^ b[(i + 6) % 8]
				^ b[(i + 7) % 8];
		return s ^ 8'h63;
	endfunction

	task automatic build_boxes();
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			s = affine(gf_inv(8'(x)));
			fwd_box[x] = s;
			rev_box[s] = 8'(x);
		end
	endtask

	// expand the current key into 44 schedule words
	task automatic expand_schedule();
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		sched[0] = key_hi_q[63:32];
		sched[1] = key_hi_q[31:0];
		sched[2] = key_lo_q[63:32];
		sched[3] = key_lo_q[31:0];
		for (int i = 4; i < 44; i++) begin
			t = sched[i - 1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_box[t[31:24]] ^ rc, fwd_box[t[23:16]], fwd_box[t[15:8]],
					fwd_box[t[7:0]]};
				rc = gf_dbl(rc);
			end
			sched[i] = sched[i - 4] ^ t;
		end
	endtask

	// inverse cipher; st[c*4+r] is row r, column c
	function automatic block_t decrypt_block(input logic [63:0] hi, input logic [63:0] lo);
		logic [7:0]  st [16];
		logic [7:0]  tmp [16];
		logic [127:0] flat;
		logic [7:0]  a0, a1, a2, a3;
		block_t      res;
		flat = {hi, lo};
		for (int i = 0; i < 16; i++)
			st[i] = flat[127 - 8 * i -: 8];
		for (int rnd = aesd_pkg::ROUNDS; rnd >= 0; rnd--) begin
			if (rnd != aesd_pkg::ROUNDS) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						tmp[c * 4 + r] = rev_box[st[((c - r + 4) % 4) * 4 + r]];
				st = tmp;
			end
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					st[c * 4 + r] ^= sched[rnd * 4 + c][31 - 8 * r -: 8];
			if (rnd != aesd_pkg::ROUNDS && rnd != 0)
				for (int c = 0; c < 4; c++) begin
					a0 = st[c * 4]; a1 = st[c * 4 + 1];
					a2 = st[c * 4 + 2]; a3 = st[c * 4 + 3];
					st[c * 4]     = gf_mul(8'h0e, a0) ^ gf_mul(8'h0b, a1)
						^ gf_mul(8'h0d, a2) ^ gf_mul(8'h09, a3);
					st[c * 4 + 1] = gf_mul(8'h09, a0) ^ gf_mul(8'h0e, a1)
						^ gf_mul(8'h0b, a2) ^ gf_mul(8'h0d, a3);
					st[c * 4 + 2] = gf_mul(8'h0d, a0) ^ gf_mul(8'h09, a1)
						^ gf_mul(8'h0e, a2) ^ gf_mul(8'h0b, a3);
					st[c * 4 + 3] = gf_mul(8'h0b, a0) ^ gf_mul(8'h0d, a1)
						^ gf_mul(8'h09, a2) ^ gf_mul(8'h0e, a3);
				end
		end
		for (int i = 0; i < 16; i++)
			flat[127 - 8 * i -: 8] = st[i];
		res.hi = flat[127:64];
		res.lo = flat[63:0];
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	// write one key half, then update the bench schedule
	task automatic write_key(input logic idx, input logic [63:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == aesd_pkg::CFG_KEY_HI)
			key_hi_q = value;
		else
			key_lo_q = value;
		expand_schedule();
		n_keys++;
	endtask

	// offer one ciphertext item and wait for acceptance
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
		input bit known, input logic [63:0] exp_hi, input logic [63:0] exp_lo);
		block_t e;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {lo, hi};
		e = decrypt_block(hi, lo);
		if (known && (e.hi !== exp_hi || e.lo !== exp_lo)) begin
			$display("%0t bench predictor disagrees with table: %h %h", $time, e.hi, e.lo);
			errors++;
		end
		if (known) begin
			e.hi = exp_hi;
			e.lo = exp_lo;
		end
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		plain_q = {plain_q, e};
		n_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (plain_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// compare each plaintext item with the oldest expectation
	always @(posedge clk) begin
		block_t e;
		block_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			n_recv++;
			if (plain_q.size() == 0) begin
				$display("%0t unexpected item: actual %h", $time, m_tdata);
				errors++;
			end else begin
				e = plain_q.pop_front();
				if (got.hi !== e.hi) begin
					$display("%0t pt_hi mismatch: expected %h actual %h", $time, e.hi, got.hi);
					errors++;
				end
				if (got.lo !== e.lo) begin
					$display("%0t pt_lo mismatch: expected %h actual %h", $time, e.lo, got.lo);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles, %0d items pending", cycles, plain_q.size());
				$display("FAIL");
				$finish;
			end
		end
	end

	// reset key: zero block under zero key decrypts from the known vector
	vector_t table_rows [5] = '{
		'{64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
		'{64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
		'{64'hffffffffffffffff, 64'h0, 1'b0, 64'h0, 64'h0},
		'{64'h0, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0}
	};
	int      phase_idle [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{16, 16}};

	initial begin
		errors = 0; n_sent = 0; n_recv = 0; n_keys = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
		s_tvalid <= 1'b0; s_tdata <= '0;
		cfg_we <= 1'b0; cfg_idx <= aesd_pkg::CFG_KEY_HI; cfg_data <= '0;
		arst_n <= 1'b0;
		build_boxes();
		key_hi_q = '0;
		key_lo_q = '0;
		expand_schedule();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_block(table_rows[i].ct_hi, table_rows[i].ct_lo, table_rows[i].known,
				table_rows[i].pt_hi, table_rows[i].pt_lo);
		drain();

		// standard appendix vector
		write_key(aesd_pkg::CFG_KEY_HI, 64'h0001020304050607);
		write_key(aesd_pkg::CFG_KEY_LO, 64'h08090a0b0c0d0e0f);
		send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
			64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(64'h0, 64'h0, 1'b0, 64'h0, 64'h0);
		drain();
		// partial update: only the upper half changes
		write_key(aesd_pkg::CFG_KEY_HI, 64'h2b7e151628aed2a6);
		send_block(64'h3925841d02dc09fb, 64'hdc118597196a0b32, 1'b0, 64'h0, 64'h0);
		drain();
		write_key(aesd_pkg::CFG_KEY_LO, 64'habf7158809cf4f3c);
		send_block(64'h3925841d02dc09fb, 64'hdc118597196a0b32, 1'b1,
			64'h3243f6a8885a308d, 64'h313198a2e0370734);
		drain();
		// all-ones key
		write_key(aesd_pkg::CFG_KEY_HI, 64'hffffffffffffffff);
		write_key(aesd_pkg::CFG_KEY_LO, 64'hffffffffffffffff);
		send_block(64'h0, 64'h0, 1'b0, 64'h0, 64'h0);
		send_block(64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0);
		drain();

		// random phases, one random key half rewritten per phase; the first phase holds off the receiver
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct  = phase_idle[ph % 4][0];
			recv_stall_pct = phase_idle[ph % 4][1];
			if ($urandom_range(0, 1))
				write_key(aesd_pkg::CFG_KEY_HI, rand64());
			else
				write_key(aesd_pkg::CFG_KEY_LO, rand64());
			if (ph == 0)
				hold_off = 1'b1;
			for (int n = 0; n < 150; n++)
				send_block(rand64(), rand64(), 1'b0, 64'h0, 64'h0);
			drain();
		end

		$display("decrypted %0d items, %0d returned, under %0d key writes", n_sent, n_recv,
			n_keys);
		$display("directed vectors, partial key updates, four idling mixes, long stall");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
sv/aesd_pkg.sv
sv/aesd_ram.sv
sv/aes128_block_decrypt.sv
test/testbench.sv
